// ----- hw/rtl/hall_capture_validator_defines.svh -----
// ----------------------------------------------------------------------------
// hall capture validator assertion macros
// shared property wrappers, clocked on the rising edge and disabled in reset
// ----------------------------------------------------------------------------
`ifndef HALL_CAPTURE_VALIDATOR_DEFINES_SVH
`define HALL_CAPTURE_VALIDATOR_DEFINES_SVH

// same-cycle implication
`define HCV_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("hcv assertion failed");

// next-cycle implication
`define HCV_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("hcv assertion failed");

`endif

// ----- hw/rtl/hcv_pkg.sv -----
// ----------------------------------------------------------------------------
// hcv_pkg
// shared types and constants of the hall capture validator
// ----------------------------------------------------------------------------
package hcv_pkg;

  localparam int unsigned TickWidth = 32;
  localparam int unsigned CntWidth  = 32;
  localparam int unsigned HallWidth = 3;

  typedef enum logic [1:0] {
    OP_CAPTURE = 2'd0,
    OP_TIMEOUT = 2'd1,
    OP_START   = 2'd2,
    OP_STOP    = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_NOT_RUNNING = 2'd1,
    ST_INVALID     = 2'd2
  } status_e;

  typedef struct packed {
    opcode_e                opcode;
    logic [TickWidth-1:0]   edge_ticks;
    logic [HallWidth-1:0]   hall_sample;
    logic                   overcapture;
    logic                   timeout_pending;
  } item_t;

  typedef struct packed {
    status_e                status;
    logic [HallWidth-1:0]   hall_now;
    logic                   sample_seen;
    logic [TickWidth-1:0]   last_ticks;
    logic [TickWidth-1:0]   interval_ticks;
    logic                   interval_ok;
    logic                   stalled;
    logic [CntWidth-1:0]    good_edges;
    logic [CntWidth-1:0]    bad_edges;
    logic [CntWidth-1:0]    timeouts;
    logic [CntWidth-1:0]    repeat_states;
    logic [CntWidth-1:0]    overruns;
  } result_t;

endpackage

// ----- hw/rtl/hcv_core.sv -----
// ----------------------------------------------------------------------------
// hcv_core
// event state, validation rules and counters; one event per fire
// ----------------------------------------------------------------------------
module hcv_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            fire_i,
  input  hcv_pkg::item_t  item_i,
  output hcv_pkg::result_t result_o
);

  logic                            running_q, running_d;
  logic [hcv_pkg::HallWidth-1:0]   hall_last_q, hall_last_d;
  logic                            have_sample_q, have_sample_d;
  logic [hcv_pkg::TickWidth-1:0]   ticks_last_q, ticks_last_d;
  logic                            interval_q, interval_d;
  logic                            timed_out_q, timed_out_d;
  logic                            ref_ok_q, ref_ok_d;
  logic                            cap_tmo_q, cap_tmo_d;
  logic [hcv_pkg::CntWidth-1:0]    good_q, good_d;
  logic [hcv_pkg::CntWidth-1:0]    bad_q, bad_d;
  logic [hcv_pkg::CntWidth-1:0]    tmo_q, tmo_d;
  logic [hcv_pkg::CntWidth-1:0]    rpt_q, rpt_d;
  logic [hcv_pkg::CntWidth-1:0]    ovr_q, ovr_d;
  hcv_pkg::status_e                status;

  always_comb begin
    logic same;
    logic bad;
    running_d     = running_q;
    hall_last_d   = hall_last_q;
    have_sample_d = have_sample_q;
    ticks_last_d  = ticks_last_q;
    interval_d    = interval_q;
    timed_out_d   = timed_out_q;
    ref_ok_d      = ref_ok_q;
    cap_tmo_d     = cap_tmo_q;
    good_d        = good_q;
    bad_d         = bad_q;
    tmo_d         = tmo_q;
    rpt_d         = rpt_q;
    ovr_d         = ovr_q;
    status        = hcv_pkg::ST_OK;
    same          = have_sample_q && (item_i.hall_sample == hall_last_q);
    bad           = (item_i.edge_ticks == '0) || item_i.overcapture || same;

    case (item_i.opcode)
      hcv_pkg::OP_CAPTURE: begin
        if (!running_q) begin
          status = hcv_pkg::ST_NOT_RUNNING;
        end else begin
          if (item_i.overcapture) begin
            ovr_d = ovr_q + 1'b1;
          end
          if (same) begin
            rpt_d = rpt_q + 1'b1;
          end else begin
            hall_last_d   = item_i.hall_sample;
            have_sample_d = 1'b1;
          end
          ticks_last_d = item_i.edge_ticks;
          timed_out_d  = 1'b0;
          cap_tmo_d    = item_i.timeout_pending;
          // interval needs a good reference and no timeout in between
          interval_d   = !bad && ref_ok_q && !item_i.timeout_pending;
          if (bad) begin
            bad_d    = bad_q + 1'b1;
            ref_ok_d = 1'b0;
            status   = hcv_pkg::ST_INVALID;
          end else begin
            good_d   = good_q + 1'b1;
            ref_ok_d = 1'b1;
          end
        end
      end
      hcv_pkg::OP_TIMEOUT: begin
        if (!running_q) begin
          status = hcv_pkg::ST_NOT_RUNNING;
        end else begin
          if (!timed_out_q || cap_tmo_q) begin
            tmo_d = tmo_q + 1'b1;
          end
          interval_d = 1'b0;
          // a timeout already seen at the last capture is absorbed
          if (cap_tmo_q) begin
            timed_out_d = 1'b0;
            cap_tmo_d   = 1'b0;
          end else begin
            timed_out_d = 1'b1;
            ref_ok_d    = 1'b0;
          end
        end
      end
      hcv_pkg::OP_START: begin
        if (!running_q) begin
          hall_last_d   = item_i.hall_sample;
          have_sample_d = 1'b1;
          ticks_last_d  = '0;
          interval_d    = 1'b0;
          timed_out_d   = 1'b0;
          ref_ok_d      = 1'b0;
          cap_tmo_d     = 1'b0;
          running_d     = 1'b1;
        end
      end
      hcv_pkg::OP_STOP: begin
        if (running_q) begin
          running_d   = 1'b0;
          ref_ok_d    = 1'b0;
          cap_tmo_d   = 1'b0;
          interval_d  = 1'b0;
          timed_out_d = 1'b0;
        end
      end
      default: begin
        status = hcv_pkg::ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q     <= 1'b0;
      hall_last_q   <= '0;
      have_sample_q <= 1'b0;
      ticks_last_q  <= '0;
      interval_q    <= 1'b0;
      timed_out_q   <= 1'b0;
      ref_ok_q      <= 1'b0;
      cap_tmo_q     <= 1'b0;
      good_q        <= '0;
      bad_q         <= '0;
      tmo_q         <= '0;
      rpt_q         <= '0;
      ovr_q         <= '0;
    end else if (fire_i) begin
      running_q     <= running_d;
      hall_last_q   <= hall_last_d;
      have_sample_q <= have_sample_d;
      ticks_last_q  <= ticks_last_d;
      interval_q    <= interval_d;
      timed_out_q   <= timed_out_d;
      ref_ok_q      <= ref_ok_d;
      cap_tmo_q     <= cap_tmo_d;
      good_q        <= good_d;
      bad_q         <= bad_d;
      tmo_q         <= tmo_d;
      rpt_q         <= rpt_d;
      ovr_q         <= ovr_d;
    end
  end

  always_comb begin
    result_o.status         = status;
    result_o.hall_now       = hall_last_d;
    result_o.sample_seen    = have_sample_d;
    result_o.last_ticks     = ticks_last_d;
    result_o.interval_ticks = interval_d ? ticks_last_d : '0;
    result_o.interval_ok    = interval_d;
    result_o.stalled        = timed_out_d;
    result_o.good_edges     = good_d;
    result_o.bad_edges      = bad_d;
    result_o.timeouts       = tmo_d;
    result_o.repeat_states  = rpt_d;
    result_o.overruns       = ovr_d;
  end

endmodule

// ----- hw/rtl/hall_capture_validator.sv -----
// ----------------------------------------------------------------------------
// hall_capture_validator
// hall-sensor edge validator with interval report and event counters
// ----------------------------------------------------------------------------
// input channel: in_valid_i / in_stall_o with one event per transfer
//   (capture, timeout, start or stop) and its fields as separate ports
// output channel: out_valid_o / out_stall_i, one result per event: status
//   plus a snapshot of hall state, last ticks, interval and counters
// order: the input register takes the event at its transfer, then the result
//   register takes the core's result for it once the event fires from there
// throughput: one event per cycle while the receiver does not stall; the state
//   update and counter increments are combinational between the two registers
// reset: running clear, all flags, hall state, ticks and counters zero,
//   both registers empty
// receiver stall: the result register holds; the input register still takes
//   one event while it is empty, and in_stall_o is high while both registers
//   hold an event and out_stall_i is high
// ----------------------------------------------------------------------------
`include "hall_capture_validator_defines.svh"

module hall_capture_validator (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [1:0]                      opcode_i,
  input  logic [hcv_pkg::TickWidth-1:0]   edge_ticks_i,
  input  logic [hcv_pkg::HallWidth-1:0]   hall_sample_i,
  input  logic                            overcapture_i,
  input  logic                            timeout_pending_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [1:0]                      status_o,
  output logic [hcv_pkg::HallWidth-1:0]   hall_now_o,
  output logic                            sample_seen_o,
  output logic [hcv_pkg::TickWidth-1:0]   last_ticks_o,
  output logic [hcv_pkg::TickWidth-1:0]   interval_ticks_o,
  output logic                            interval_ok_o,
  output logic                            stalled_o,
  output logic [hcv_pkg::CntWidth-1:0]    good_edges_o,
  output logic [hcv_pkg::CntWidth-1:0]    bad_edges_o,
  output logic [hcv_pkg::CntWidth-1:0]    timeouts_o,
  output logic [hcv_pkg::CntWidth-1:0]    repeat_states_o,
  output logic [hcv_pkg::CntWidth-1:0]    overruns_o
);

  logic             in_valid_q;
  hcv_pkg::item_t   in_item_q;
  logic             out_valid_q;
  hcv_pkg::result_t out_res_q;
  hcv_pkg::result_t core_res;
  logic             out_adv;
  logic             fire;
  logic             in_take;

  assign out_adv    = !out_valid_q || !out_stall_i;
  assign fire       = in_valid_q && out_adv;
  assign in_stall_o = in_valid_q && !out_adv;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_item_q.opcode          <= hcv_pkg::opcode_e'(opcode_i);
      in_item_q.edge_ticks      <= edge_ticks_i;
      in_item_q.hall_sample     <= hall_sample_i;
      in_item_q.overcapture     <= overcapture_i;
      in_item_q.timeout_pending <= timeout_pending_i;
    end
  end

  hcv_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .item_i   (in_item_q),
    .result_o (core_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_adv) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_res_q <= core_res;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = out_res_q.status;
  assign hall_now_o       = out_res_q.hall_now;
  assign sample_seen_o    = out_res_q.sample_seen;
  assign last_ticks_o     = out_res_q.last_ticks;
  assign interval_ticks_o = out_res_q.interval_ticks;
  assign interval_ok_o    = out_res_q.interval_ok;
  assign stalled_o        = out_res_q.stalled;
  assign good_edges_o     = out_res_q.good_edges;
  assign bad_edges_o      = out_res_q.bad_edges;
  assign timeouts_o       = out_res_q.timeouts;
  assign repeat_states_o  = out_res_q.repeat_states;
  assign overruns_o       = out_res_q.overruns;

  // a valid interval only comes from a good capture
  `HCV_ASSERT_IMPL(a_interval_status, clk_i, rst_ni,
    out_valid_o && interval_ok_o,
    (status_o == hcv_pkg::ST_OK) && (interval_ticks_o == last_ticks_o) && (last_ticks_o != '0))

  // an empty result register never pushes back on the input side
  `HCV_ASSERT_IMPL(a_no_stall_when_empty, clk_i, rst_ni,
    !out_valid_o,
    !in_stall_o)

  // an accepted event always reaches the result register
  `HCV_ASSERT_NEXT(a_fire_to_out, clk_i, rst_ni,
    fire,
    out_valid_o)

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hall capture validator testbench
// drives start, stop, capture and timeout events through the valid/stall
// input channel, predicts the status and snapshot of every event and checks
// each result transfer field by field, under several idle and stall mixes
// ----------------------------------------------------------------------------
module tb;

  typedef struct {
    hcv_pkg::item_t   ev;
    bit               typed;
    hcv_pkg::result_t want;
  } dir_row_t;

  logic                          clk;
  logic                          rst_ni;
  logic                          in_valid_i;
  logic                          in_stall_o;
  logic [1:0]                    opcode_i;
  logic [hcv_pkg::TickWidth-1:0] edge_ticks_i;
  logic [hcv_pkg::HallWidth-1:0] hall_sample_i;
  logic                          overcapture_i;
  logic                          timeout_pending_i;
  logic                          out_valid_o;
  logic                          out_stall_i;
  logic [1:0]                    status_o;
  logic [hcv_pkg::HallWidth-1:0] hall_now_o;
  logic                          sample_seen_o;
  logic [hcv_pkg::TickWidth-1:0] last_ticks_o;
  logic [hcv_pkg::TickWidth-1:0] interval_ticks_o;
  logic                          interval_ok_o;
  logic                          stalled_o;
  logic [hcv_pkg::CntWidth-1:0]  good_edges_o;
  logic [hcv_pkg::CntWidth-1:0]  bad_edges_o;
  logic [hcv_pkg::CntWidth-1:0]  timeouts_o;
  logic [hcv_pkg::CntWidth-1:0]  repeat_states_o;
  logic [hcv_pkg::CntWidth-1:0]  overruns_o;

  // predicted block state
  logic                          p_running;
  logic [hcv_pkg::HallWidth-1:0] p_hall;
  logic                          p_seen;
  logic [hcv_pkg::TickWidth-1:0] p_ticks;
  logic                          p_intv;
  logic                          p_stalled;
  logic                          p_ref_ok;
  logic                          p_cap_to;
  logic [hcv_pkg::CntWidth-1:0]  p_good;
  logic [hcv_pkg::CntWidth-1:0]  p_bad;
  logic [hcv_pkg::CntWidth-1:0]  p_timeouts;
  logic [hcv_pkg::CntWidth-1:0]  p_repeats;
  logic [hcv_pkg::CntWidth-1:0]  p_overruns;

  hcv_pkg::result_t expected_snaps[$];
  dir_row_t         dir_tab[$];
  int               mismatches;
  int               send_idle_pct;
  int               stall_pct;
  int               hold_cycles;

  hall_capture_validator dut (
    .clk_i             (clk),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .opcode_i          (opcode_i),
    .edge_ticks_i      (edge_ticks_i),
    .hall_sample_i     (hall_sample_i),
    .overcapture_i     (overcapture_i),
    .timeout_pending_i (timeout_pending_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .status_o          (status_o),
    .hall_now_o        (hall_now_o),
    .sample_seen_o     (sample_seen_o),
    .last_ticks_o      (last_ticks_o),
    .interval_ticks_o  (interval_ticks_o),
    .interval_ok_o     (interval_ok_o),
    .stalled_o         (stalled_o),
    .good_edges_o      (good_edges_o),
    .bad_edges_o       (bad_edges_o),
    .timeouts_o        (timeouts_o),
    .repeat_states_o   (repeat_states_o),
    .overruns_o        (overruns_o)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic hcv_pkg::item_t make_event(hcv_pkg::opcode_e op, logic [31:0] ticks,
                                                logic [2:0] hall, logic oc, logic pend);
    hcv_pkg::item_t e;
    e.opcode          = op;
    e.edge_ticks      = ticks;
    e.hall_sample     = hall;
    e.overcapture     = oc;
    e.timeout_pending = pend;
    return e;
  endfunction

  // snapshot with no interval and not stalled
  function automatic hcv_pkg::result_t snapshot(hcv_pkg::status_e st, logic [2:0] hall,
                                                logic seen, logic [31:0] ticks,
                                                logic [31:0] good, logic [31:0] bad,
                                                logic [31:0] tmo, logic [31:0] rep,
                                                logic [31:0] ovr);
    hcv_pkg::result_t r;
    r               = '0;
    r.status        = st;
    r.hall_now      = hall;
    r.sample_seen   = seen;
    r.last_ticks    = ticks;
    r.good_edges    = good;
    r.bad_edges     = bad;
    r.timeouts      = tmo;
    r.repeat_states = rep;
    r.overruns      = ovr;
    return r;
  endfunction

  function automatic void clear_prediction();
    p_running  = 1'b0;
    p_hall     = '0;
    p_seen     = 1'b0;
    p_ticks    = '0;
    p_intv     = 1'b0;
    p_stalled  = 1'b0;
    p_ref_ok   = 1'b0;
    p_cap_to   = 1'b0;
    p_good     = '0;
    p_bad      = '0;
    p_timeouts = '0;
    p_repeats  = '0;
    p_overruns = '0;
  endfunction

  // applies one event to the predicted state and returns the snapshot after it
  function automatic hcv_pkg::result_t predict_snapshot(hcv_pkg::item_t ev);
    logic             same;
    logic             bad;
    hcv_pkg::status_e st;
    hcv_pkg::result_t r;
    st = hcv_pkg::ST_OK;
    case (ev.opcode)
      hcv_pkg::OP_CAPTURE: begin
        if (!p_running) begin
          st = hcv_pkg::ST_NOT_RUNNING;
        end else begin
          if (ev.overcapture) p_overruns = p_overruns + 1;
          same = p_seen && (ev.hall_sample == p_hall);
          bad  = (ev.edge_ticks == 0) || ev.overcapture || same;
          if (same) begin
            p_repeats = p_repeats + 1;
          end else begin
            p_hall = ev.hall_sample;
            p_seen = 1'b1;
          end
          p_ticks   = ev.edge_ticks;
          p_stalled = 1'b0;
          p_cap_to  = ev.timeout_pending;
          p_intv    = !bad && p_ref_ok && !ev.timeout_pending;
          if (bad) begin
            p_bad    = p_bad + 1;
            p_ref_ok = 1'b0;
            st       = hcv_pkg::ST_INVALID;
          end else begin
            p_good   = p_good + 1;
            p_ref_ok = 1'b1;
          end
        end
      end
      hcv_pkg::OP_TIMEOUT: begin
        if (!p_running) begin
          st = hcv_pkg::ST_NOT_RUNNING;
        end else begin
          // a repeated timeout while stalled is not counted again
          if (!p_stalled || p_cap_to) p_timeouts = p_timeouts + 1;
          p_intv = 1'b0;
          if (p_cap_to) begin
            p_stalled = 1'b0;
            p_cap_to  = 1'b0;
          end else begin
            p_stalled = 1'b1;
            p_ref_ok  = 1'b0;
          end
        end
      end
      hcv_pkg::OP_START: begin
        if (!p_running) begin
          p_hall    = ev.hall_sample;
          p_seen    = 1'b1;
          p_ticks   = '0;
          p_intv    = 1'b0;
          p_stalled = 1'b0;
          p_ref_ok  = 1'b0;
          p_cap_to  = 1'b0;
          p_running = 1'b1;
        end
      end
      default: begin
        if (p_running) begin
          p_running = 1'b0;
          p_ref_ok  = 1'b0;
          p_cap_to  = 1'b0;
          p_intv    = 1'b0;
          p_stalled = 1'b0;
        end
      end
    endcase
    r.status         = st;
    r.hall_now       = p_hall;
    r.sample_seen    = p_seen;
    r.last_ticks     = p_ticks;
    r.interval_ticks = p_intv ? p_ticks : '0;
    r.interval_ok    = p_intv;
    r.stalled        = p_stalled;
    r.good_edges     = p_good;
    r.bad_edges      = p_bad;
    r.timeouts       = p_timeouts;
    r.repeat_states  = p_repeats;
    r.overruns       = p_overruns;
    return r;
  endfunction

  // six-step commutation neighbor of a hall state
  function automatic logic [2:0] commutate(logic [2:0] h, bit fwd);
    case (h)
      3'd1:    return fwd ? 3'd3 : 3'd5;
      3'd3:    return fwd ? 3'd2 : 3'd1;
      3'd2:    return fwd ? 3'd6 : 3'd3;
      3'd6:    return fwd ? 3'd4 : 3'd2;
      3'd4:    return fwd ? 3'd5 : 3'd6;
      3'd5:    return fwd ? 3'd1 : 3'd4;
      default: return 3'd1;
    endcase
  endfunction

  // mostly a rotating motor: start, then commutating captures with a few
  // timeouts and stops; the rest is noise on hall, ticks and flags
  function automatic hcv_pkg::item_t random_event();
    int               pick;
    hcv_pkg::opcode_e op;
    logic [31:0]      ticks;
    logic [2:0]       hall;
    pick = $urandom_range(99);
    if (p_running) begin
      if (pick < 78)      op = hcv_pkg::OP_CAPTURE;
      else if (pick < 90) op = hcv_pkg::OP_TIMEOUT;
      else if (pick < 95) op = hcv_pkg::OP_STOP;
      else                op = hcv_pkg::OP_START;
    end else begin
      if (pick < 70)      op = hcv_pkg::OP_START;
      else if (pick < 80) op = hcv_pkg::OP_CAPTURE;
      else if (pick < 90) op = hcv_pkg::OP_TIMEOUT;
      else                op = hcv_pkg::OP_STOP;
    end
    case ($urandom_range(15))
      0:       ticks = '0;
      1:       ticks = '1;
      2, 3, 4, 5, 6, 7, 8, 9: ticks = $urandom_range(5000, 1);
      default: ticks = $urandom();
    endcase
    if (op == hcv_pkg::OP_CAPTURE && $urandom_range(99) >= 15)
      hall = commutate(p_hall, $urandom_range(9) != 0);
    else
      hall = 3'($urandom_range(7));
    return make_event(op, ticks, hall, $urandom_range(9) == 0, $urandom_range(7) == 0);
  endfunction

  task automatic send_event(hcv_pkg::item_t ev, bit typed, hcv_pkg::result_t want);
    hcv_pkg::result_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_valid_i = 1'b0;
      @(posedge clk);
    end
    @(negedge clk);
    in_valid_i        = 1'b1;
    opcode_i          = ev.opcode;
    edge_ticks_i      = ev.edge_ticks;
    hall_sample_i     = ev.hall_sample;
    overcapture_i     = ev.overcapture;
    timeout_pending_i = ev.timeout_pending;
    @(posedge clk);
    while (in_stall_o) @(posedge clk);
    predicted = predict_snapshot(ev);
    expected_snaps.push_back(typed ? want : predicted);
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid_i = 1'b0;
    while (expected_snaps.size() != 0) @(posedge clk);
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  // receiver: random stall, or a counted hold-off when one is requested
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_stall_i = 1'b1;
        hold_cycles--;
      end else begin
        out_stall_i = ($urandom_range(99) < stall_pct);
      end
    end
  end

  always @(posedge clk) begin : result_check
    hcv_pkg::result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_snaps.size() == 0) begin
        mismatches++;
        $display("%0t: result transfer with nothing expected, status %0d", $time, status_o);
      end else begin
        want = expected_snaps.pop_front();
        check_field("status", want.status, status_o);
        check_field("hall_now", want.hall_now, hall_now_o);
        check_field("sample_seen", want.sample_seen, sample_seen_o);
        check_field("last_ticks", want.last_ticks, last_ticks_o);
        check_field("interval_ticks", want.interval_ticks, interval_ticks_o);
        check_field("interval_ok", want.interval_ok, interval_ok_o);
        check_field("stalled", want.stalled, stalled_o);
        check_field("good_edges", want.good_edges, good_edges_o);
        check_field("bad_edges", want.bad_edges, bad_edges_o);
        check_field("timeouts", want.timeouts, timeouts_o);
        check_field("repeat_states", want.repeat_states, repeat_states_o);
        check_field("overruns", want.overruns, overruns_o);
      end
    end
  end

  initial begin
    dir_row_t         row;
    hcv_pkg::result_t zero_snap;
    hcv_pkg::result_t idle_snap;
    int               phase;
    int               n;

    rst_ni            = 1'b0;
    in_valid_i        = 1'b0;
    opcode_i          = hcv_pkg::OP_CAPTURE;
    edge_ticks_i      = '0;
    hall_sample_i     = '0;
    overcapture_i     = 1'b0;
    timeout_pending_i = 1'b0;
    mismatches        = 0;
    send_idle_pct     = 0;
    stall_pct         = 0;
    hold_cycles       = 0;
    clear_prediction();

    idle_snap = snapshot(hcv_pkg::ST_NOT_RUNNING, 3'd0, 1'b0, '0, '0, '0, '0, '0, '0);
    zero_snap = snapshot(hcv_pkg::ST_OK, 3'd0, 1'b0, '0, '0, '0, '0, '0, '0);

    // events before start leave the reset state untouched
    dir_tab.push_back('{make_event(hcv_pkg::OP_CAPTURE, '1, 3'd7, 1'b1, 1'b1), 1'b1,
                        idle_snap});
    dir_tab.push_back('{make_event(hcv_pkg::OP_TIMEOUT, '1, 3'd7, 1'b1, 1'b1), 1'b1,
                        idle_snap});
    dir_tab.push_back('{make_event(hcv_pkg::OP_STOP, '0, 3'd0, 1'b0, 1'b0), 1'b1, zero_snap});
    row = '{make_event(hcv_pkg::OP_START, '1, 3'd5, 1'b1, 1'b1), 1'b1,
            snapshot(hcv_pkg::ST_OK, 3'd5, 1'b1, '0, '0, '0, '0, '0, '0)};
    dir_tab.push_back(row);
    // start while running changes nothing
    row.ev = make_event(hcv_pkg::OP_START, 32'd77, 3'd2, 1'b0, 1'b0);
    dir_tab.push_back(row);
    // zero ticks is an invalid capture
    dir_tab.push_back('{make_event(hcv_pkg::OP_CAPTURE, '0, 3'd4, 1'b0, 1'b0), 1'b1,
                        snapshot(hcv_pkg::ST_INVALID, 3'd4, 1'b1, '0, '0, 32'd1, '0, '0,
                                 '0)});
    dir_tab.push_back('{make_event(hcv_pkg::OP_CAPTURE, '1, 3'd6, 1'b0, 1'b0), 1'b0, '0});
    dir_tab.push_back('{make_event(hcv_pkg::OP_CAPTURE, 32'd1, 3'd2, 1'b0, 1'b0), 1'b0, '0});
    // repeated hall state, then an overrun
    dir_tab.push_back('{make_event(hcv_pkg::OP_CAPTURE, 32'd100, 3'd2, 1'b0, 1'b0), 1'b0,
                        '0});
    dir_tab.push_back('{make_event(hcv_pkg::OP_CAPTURE, 32'd50, 3'd3, 1'b1, 1'b0), 1'b0, '0});
    dir_tab.push_back('{make_event(hcv_pkg::OP_CAPTURE, 32'd7, 3'd1, 1'b0, 1'b0), 1'b0, '0});
    // capture with a pending timeout, which the next timeout absorbs
    dir_tab.push_back('{make_event(hcv_pkg::OP_CAPTURE, 32'd8, 3'd5, 1'b0, 1'b1), 1'b0, '0});
    dir_tab.push_back('{make_event(hcv_pkg::OP_TIMEOUT, '0, 3'd0, 1'b0, 1'b0), 1'b0, '0});
    dir_tab.push_back('{make_event(hcv_pkg::OP_CAPTURE, 32'd9, 3'd4, 1'b0, 1'b0), 1'b0, '0});
    // real stall, then a second timeout that is not counted
    dir_tab.push_back('{make_event(hcv_pkg::OP_TIMEOUT, '1, 3'd7, 1'b1, 1'b1), 1'b0, '0});
    dir_tab.push_back('{make_event(hcv_pkg::OP_TIMEOUT, '0, 3'd0, 1'b0, 1'b0), 1'b0, '0});
    dir_tab.push_back('{make_event(hcv_pkg::OP_CAPTURE, '1, 3'd6, 1'b0, 1'b0), 1'b0, '0});
    dir_tab.push_back('{make_event(hcv_pkg::OP_CAPTURE, '1, 3'd2, 1'b0, 1'b0), 1'b0, '0});
    dir_tab.push_back('{make_event(hcv_pkg::OP_STOP, '1, 3'd7, 1'b1, 1'b1), 1'b0, '0});
    dir_tab.push_back('{make_event(hcv_pkg::OP_CAPTURE, 32'd5, 3'd3, 1'b0, 1'b0), 1'b0, '0});
    dir_tab.push_back('{make_event(hcv_pkg::OP_TIMEOUT, '0, 3'd0, 1'b0, 1'b0), 1'b0, '0});
    dir_tab.push_back('{make_event(hcv_pkg::OP_START, '0, 3'd0, 1'b0, 1'b0), 1'b0, '0});
    dir_tab.push_back('{make_event(hcv_pkg::OP_CAPTURE, 32'd3, 3'd0, 1'b0, 1'b0), 1'b0, '0});
    dir_tab.push_back('{make_event(hcv_pkg::OP_CAPTURE, 32'd3, 3'd7, 1'b1, 1'b1), 1'b0, '0});
    dir_tab.push_back('{make_event(hcv_pkg::OP_STOP, '0, 3'd0, 1'b0, 1'b0), 1'b0, '0});

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_ni = 1'b1;

    foreach (dir_tab[i]) send_event(dir_tab[i].ev, dir_tab[i].typed, dir_tab[i].want);

    // no idling, sender idle, receiver stalling, both
    for (phase = 0; phase < 4; phase++) begin
      send_idle_pct = (phase == 1) ? 55 : (phase == 3) ? 23 : 0;
      stall_pct     = (phase == 2) ? 55 : (phase == 3) ? 23 : 0;
      for (n = 0; n < 455; n++) send_event(random_event(), 1'b0, '0);
      // sender pauses until every result has come back
      drain_results();
    end

    // long receiver hold-off while events keep coming, so the input stalls
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_cycles   = 60;
    for (n = 0; n < 40; n++) send_event(random_event(), 1'b0, '0);
    drain_results();

    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
